FILE: design/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg: shared constants for the two-axis stepper positioner
// Coil drive tables, nibble masks, widths and configuration register map.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // Field widths
    localparam int POS_W   = 8;
    localparam int PHASE_W = 2;
    localparam int COIL_W  = 8;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    // One-phase-on coil codes, indexed by phase
    localparam logic [COIL_W-1:0] X_COILS [4] = '{8'h01, 8'h02, 8'h04, 8'h08};
    localparam logic [COIL_W-1:0] Y_COILS [4] = '{8'h10, 8'h20, 8'h40, 8'h80};

    // Nibble kept when the other axis steps
    localparam logic [COIL_W-1:0] KEEP_Y_MASK = 8'hF0;
    localparam logic [COIL_W-1:0] KEEP_X_MASK = 8'h0F;

    // Configuration register byte addresses
    localparam logic [ADDR_W-1:0] REG_DESK_WIDTH    = 4'd0;
    localparam logic [ADDR_W-1:0] REG_DESK_HEIGHT   = 4'd4;
    localparam logic [ADDR_W-1:0] REG_ALLOW_OVERRUN = 4'd8;

    // Configuration reset values
    localparam logic [POS_W-1:0] DESK_WIDTH_RST  = 8'd128;
    localparam logic [POS_W-1:0] DESK_HEIGHT_RST = 8'd64;

    // Request kinds
    localparam logic REQ_TARGET = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

endpackage

FILE: design/two_axis_stepper_positioner.sv
// ----------------------------------------------------------------------------
// two_axis_stepper_positioner: full-step two-axis head positioner
// Takes target and tick requests, steps one axis per tick through a
// one-phase-on coil ring and gates the laser by the desk limits.
// ----------------------------------------------------------------------------
// Each request passes from acceptance through the input register, then through
// one pass of compare, increment and table logic into the result register,
// where the head state is updated too. A new request is
// accepted in every cycle while the result side keeps taking results; a held
// result stalls the input register, and the input side stalls only once that
// register is full as well. Configuration registers sit at byte addresses 0
// (desk width), 4 (desk height) and 8 (allow overrun); the APB port is always
// ready and reads back every register.
module two_axis_stepper_positioner (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsp_pkg::ADDR_W-1:0]  paddr,
    input  logic [tsp_pkg::DATA_W-1:0]  pwdata,
    output logic [tsp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_req_type,
    input  logic [tsp_pkg::POS_W-1:0]   i_target_x,
    input  logic [tsp_pkg::POS_W-1:0]   i_target_y,
    input  logic                        i_laser_request,
    // Result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tsp_pkg::COIL_W-1:0]  o_coil_pattern,
    output logic [tsp_pkg::POS_W-1:0]   o_head_x,
    output logic [tsp_pkg::POS_W-1:0]   o_head_y,
    output logic                        o_busy_res,
    output logic                        o_target_rejected,
    output logic                        o_step_blocked,
    output logic                        o_laser_out
);

    // Configuration registers
    logic [tsp_pkg::POS_W-1:0]   r_desk_width;
    logic [tsp_pkg::POS_W-1:0]   r_desk_height;
    logic                        r_allow_overrun;

    // Head state
    logic [tsp_pkg::POS_W-1:0]   r_pos_x,   n_pos_x;
    logic [tsp_pkg::POS_W-1:0]   r_pos_y,   n_pos_y;
    logic [tsp_pkg::PHASE_W-1:0] r_phase_x, n_phase_x;
    logic [tsp_pkg::PHASE_W-1:0] r_phase_y, n_phase_y;
    logic [tsp_pkg::POS_W-1:0]   r_goal_x,  n_goal_x;
    logic [tsp_pkg::POS_W-1:0]   r_goal_y,  n_goal_y;
    logic                        r_moving,  n_moving;
    logic [tsp_pkg::COIL_W-1:0]  r_coil,    n_coil;

    // Input register
    logic                        r_in_valid;
    logic                        r_in_req_type;
    logic [tsp_pkg::POS_W-1:0]   r_in_target_x;
    logic [tsp_pkg::POS_W-1:0]   r_in_target_y;
    logic                        r_in_laser_request;

    // Result register
    logic                        r_out_valid;
    logic                        r_out_rejected, n_rejected;
    logic                        r_out_blocked,  n_blocked;
    logic                        r_out_laser,    n_laser;

    // Handshake
    logic                        out_free;
    logic                        advance;
    logic                        in_accept;
    logic                        cfg_write;

    // Axis step terms
    logic                        x_up, y_up;
    logic [tsp_pkg::POS_W:0]     x_next, y_next;
    logic                        x_blk, y_blk;
    logic [tsp_pkg::PHASE_W-1:0] x_ph, y_ph;

    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Read back configuration
    always_comb begin
        prdata = '0;
        case (paddr)
            tsp_pkg::REG_DESK_WIDTH:    prdata = {{(tsp_pkg::DATA_W-tsp_pkg::POS_W){1'b0}},
                                                  r_desk_width};
            tsp_pkg::REG_DESK_HEIGHT:   prdata = {{(tsp_pkg::DATA_W-tsp_pkg::POS_W){1'b0}},
                                                  r_desk_height};
            tsp_pkg::REG_ALLOW_OVERRUN: prdata = {{(tsp_pkg::DATA_W-1){1'b0}},
                                                  r_allow_overrun};
            default:                    prdata = '0;
        endcase
    end

    // Work out one step of each axis toward the goal
    always_comb begin
        x_up   = r_pos_x < r_goal_x;
        x_next = x_up ? {1'b0, r_pos_x} + 9'd1 : {1'b0, r_pos_x} - 9'd1;
        x_blk  = (!x_up && r_pos_x == '0) || (x_up && r_pos_x == '1) ||
                 (x_next > {1'b0, r_desk_width} && !r_allow_overrun);
        x_ph   = x_up ? r_phase_x + 2'd1 : r_phase_x - 2'd1;

        y_up   = r_pos_y < r_goal_y;
        y_next = y_up ? {1'b0, r_pos_y} + 9'd1 : {1'b0, r_pos_y} - 9'd1;
        y_blk  = (!y_up && r_pos_y == '0) || (y_up && r_pos_y == '1) ||
                 (y_next > {1'b0, r_desk_height} && !r_allow_overrun);
        y_ph   = y_up ? r_phase_y + 2'd1 : r_phase_y - 2'd1;
    end

    // Next head state and result flags for the held request
    always_comb begin
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_phase_x  = r_phase_x;
        n_phase_y  = r_phase_y;
        n_goal_x   = r_goal_x;
        n_goal_y   = r_goal_y;
        n_moving   = r_moving;
        n_coil     = r_coil;
        n_rejected = 1'b0;
        n_blocked  = 1'b0;

        if (r_in_req_type == tsp_pkg::REQ_TARGET) begin
            if (r_in_target_x < r_desk_width && r_in_target_y < r_desk_height) begin
                n_goal_x = r_in_target_x;
                n_goal_y = r_in_target_y;
                n_moving = (r_pos_x != r_in_target_x) || (r_pos_y != r_in_target_y);
            end else begin
                n_rejected = 1'b1;
                n_moving   = 1'b0;
            end
        end else if (r_moving) begin
            if (r_pos_x != r_goal_x) begin
                if (x_blk) begin
                    n_blocked = 1'b1;
                end else begin
                    n_pos_x   = x_next[tsp_pkg::POS_W-1:0];
                    n_phase_x = x_ph;
                    n_coil    = (r_coil & tsp_pkg::KEEP_Y_MASK) | tsp_pkg::X_COILS[x_ph];
                end
            end else if (r_pos_y != r_goal_y) begin
                if (y_blk) begin
                    n_blocked = 1'b1;
                end else begin
                    n_pos_y   = y_next[tsp_pkg::POS_W-1:0];
                    n_phase_y = y_ph;
                    n_coil    = (r_coil & tsp_pkg::KEEP_X_MASK) | tsp_pkg::Y_COILS[y_ph];
                end
            end
            n_moving = (n_pos_x != r_goal_x) || (n_pos_y != r_goal_y);
        end

        n_laser = !n_rejected && r_in_laser_request &&
                  (n_pos_x <= r_desk_width) && (n_pos_y <= r_desk_height);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desk_width    <= tsp_pkg::DESK_WIDTH_RST;
            r_desk_height   <= tsp_pkg::DESK_HEIGHT_RST;
            r_allow_overrun <= 1'b0;
        end else if (cfg_write) begin
            case (paddr)
                tsp_pkg::REG_DESK_WIDTH:    r_desk_width    <= pwdata[tsp_pkg::POS_W-1:0];
                tsp_pkg::REG_DESK_HEIGHT:   r_desk_height   <= pwdata[tsp_pkg::POS_W-1:0];
                tsp_pkg::REG_ALLOW_OVERRUN: r_allow_overrun <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Input register: take a request whenever it is free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_req_type      <= i_req_type;
            r_in_target_x      <= i_target_x;
            r_in_target_y      <= i_target_y;
            r_in_laser_request <= i_laser_request;
        end
    end

    // Head state: advance when the request moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_phase_x <= '0;
            r_phase_y <= '0;
            r_goal_x  <= '0;
            r_goal_y  <= '0;
            r_moving  <= 1'b0;
            r_coil    <= '0;
        end else if (advance) begin
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_phase_x <= n_phase_x;
            r_phase_y <= n_phase_y;
            r_goal_x  <= n_goal_x;
            r_goal_y  <= n_goal_y;
            r_moving  <= n_moving;
            r_coil    <= n_coil;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_rejected <= n_rejected;
            r_out_blocked  <= n_blocked;
            r_out_laser    <= n_laser;
        end
    end

    // The head state registers double as the result payload
    assign o_valid           = r_out_valid;
    assign o_coil_pattern    = r_coil;
    assign o_head_x          = r_pos_x;
    assign o_head_y          = r_pos_y;
    assign o_busy_res        = r_moving;
    assign o_target_rejected = r_out_rejected;
    assign o_step_blocked    = r_out_blocked;
    assign o_laser_out       = r_out_laser;

    // At most one coil driven per axis
    a_coil_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_coil[3:0]) && $onehot0(r_coil[7:4]))
        else $error("more than one coil driven on an axis");

    // A rejected target leaves the head idle with the laser off
    a_reject_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_target_rejected |-> !o_busy_res && !o_laser_out)
        else $error("rejected target left head busy or laser on");

    // A result is either a rejected target or a blocked tick, never both
    a_reject_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_target_rejected && o_step_blocked))
        else $error("result flagged both rejected and blocked");

    // Head state changes only when a request moves into the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_pos_x) && $stable(r_pos_y) && $stable(r_coil))
        else $error("head state changed without a request");

endmodule

FILE: tb/sv/tb_two_axis_stepper_positioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_axis_stepper_positioner: self-checking bench for the head positioner
// Drives target and tick requests through the valid/stall channel, predicts
// coil byte, head position, busy, rejection, blocking and laser for every
// request, and compares each result in order. Desk limits and overrun are
// reprogrammed over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_two_axis_stepper_positioner;

    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic                      kind;
        logic [tsp_pkg::POS_W-1:0] tx;
        logic [tsp_pkg::POS_W-1:0] ty;
        logic                      laser;
    } t_head_req;

    typedef struct packed {
        logic [tsp_pkg::COIL_W-1:0] coils;
        logic [tsp_pkg::POS_W-1:0]  x;
        logic [tsp_pkg::POS_W-1:0]  y;
        logic                       busy;
        logic                       rejected;
        logic                       blocked;
        logic                       laser;
    } t_head_result;

    typedef struct packed {
        logic                        blocked;
        logic [tsp_pkg::PHASE_W-1:0] phase;
        logic [tsp_pkg::POS_W-1:0]   pos;
    } t_axis_move;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [tsp_pkg::ADDR_W-1:0] paddr = '0;
    logic [tsp_pkg::DATA_W-1:0] pwdata = '0;
    logic [tsp_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic                       i_req_type = 1'b0;
    logic [tsp_pkg::POS_W-1:0]  i_target_x = '0;
    logic [tsp_pkg::POS_W-1:0]  i_target_y = '0;
    logic                       i_laser_request = 1'b0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [tsp_pkg::COIL_W-1:0] o_coil_pattern;
    logic [tsp_pkg::POS_W-1:0]  o_head_x;
    logic [tsp_pkg::POS_W-1:0]  o_head_y;
    logic                       o_busy_res;
    logic                       o_target_rejected;
    logic                       o_step_blocked;
    logic                       o_laser_out;

    // Predicted head state and desk configuration
    logic [tsp_pkg::POS_W-1:0]   head_x = '0;
    logic [tsp_pkg::POS_W-1:0]   head_y = '0;
    logic [tsp_pkg::PHASE_W-1:0] phase_x = '0;
    logic [tsp_pkg::PHASE_W-1:0] phase_y = '0;
    logic [tsp_pkg::POS_W-1:0]   goal_x = '0;
    logic [tsp_pkg::POS_W-1:0]   goal_y = '0;
    logic                        head_moving = 1'b0;
    logic [tsp_pkg::COIL_W-1:0]  coil_byte = '0;
    logic [tsp_pkg::POS_W-1:0]   desk_w = tsp_pkg::DESK_WIDTH_RST;
    logic [tsp_pkg::POS_W-1:0]   desk_h = tsp_pkg::DESK_HEIGHT_RST;
    logic                        overrun_en = 1'b0;

    t_head_req    pending_requests[$];
    t_head_result expected_heads[$];

    bit req_taken = 1'b0;
    int tx_idle_pct = 35;
    int rx_idle_pct = 72;
    int hold_request = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int plan_x = 0;
    int plan_y = 0;

    two_axis_stepper_positioner dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_target_x        (i_target_x),
        .i_target_y        (i_target_y),
        .i_laser_request   (i_laser_request),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_coil_pattern    (o_coil_pattern),
        .o_head_x          (o_head_x),
        .o_head_y          (o_head_y),
        .o_busy_res        (o_busy_res),
        .o_target_rejected (o_target_rejected),
        .o_step_blocked    (o_step_blocked),
        .o_laser_out       (o_laser_out)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out one step of an axis toward its goal, or flag it as blocked
    function automatic t_axis_move step_axis(input logic [tsp_pkg::POS_W-1:0] pos,
                                             input logic [tsp_pkg::POS_W-1:0] goal,
                                             input logic [tsp_pkg::POS_W-1:0] limit,
                                             input logic [tsp_pkg::PHASE_W-1:0] ph);
        t_axis_move mv;
        logic       up;
        up         = pos < goal;
        mv.pos     = up ? pos + 8'd1 : pos - 8'd1;
        mv.phase   = up ? ph + 2'd1 : ph - 2'd1;
        mv.blocked = (up && pos == 8'hFF) || (!up && pos == 8'h00)
                   || (mv.pos > limit && !overrun_en);
        return mv;
    endfunction

    // Advance the predicted head by one request and return its result
    function automatic t_head_result advance_head(input t_head_req r);
        t_head_result res;
        t_axis_move   mv;
        logic         rejected;
        logic         blocked;
        rejected = 1'b0;
        blocked  = 1'b0;
        if (r.kind == tsp_pkg::REQ_TARGET) begin
            if (r.tx < desk_w && r.ty < desk_h) begin
                goal_x      = r.tx;
                goal_y      = r.ty;
                head_moving = (head_x != goal_x) || (head_y != goal_y);
            end else begin
                rejected    = 1'b1;
                head_moving = 1'b0;
            end
        end else if (head_moving) begin
            // X first, Y only once X has arrived
            if (head_x != goal_x) begin
                mv      = step_axis(head_x, goal_x, desk_w, phase_x);
                blocked = mv.blocked;
                if (!mv.blocked) begin
                    head_x    = mv.pos;
                    phase_x   = mv.phase;
                    coil_byte = (coil_byte & tsp_pkg::KEEP_Y_MASK)
                              | tsp_pkg::X_COILS[mv.phase];
                end
            end else if (head_y != goal_y) begin
                mv      = step_axis(head_y, goal_y, desk_h, phase_y);
                blocked = mv.blocked;
                if (!mv.blocked) begin
                    head_y    = mv.pos;
                    phase_y   = mv.phase;
                    coil_byte = (coil_byte & tsp_pkg::KEEP_X_MASK)
                              | tsp_pkg::Y_COILS[mv.phase];
                end
            end
            head_moving = (head_x != goal_x) || (head_y != goal_y);
        end
        res.coils    = coil_byte;
        res.x        = head_x;
        res.y        = head_y;
        res.busy     = head_moving;
        res.rejected = rejected;
        res.blocked  = blocked;
        res.laser    = !rejected && r.laser && head_x <= desk_w && head_y <= desk_h;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
        mismatch_count++;
    endtask

    task automatic queue_req(input logic kind, input logic [tsp_pkg::POS_W-1:0] tx,
                             input logic [tsp_pkg::POS_W-1:0] ty, input logic laser);
        t_head_req r;
        r.kind  = kind;
        r.tx    = tx;
        r.ty    = ty;
        r.laser = laser;
        pending_requests.push_back(r);
    endtask

    // APB write: setup cycle, then access cycle; update the predicted desk
    task automatic write_reg(input logic [tsp_pkg::ADDR_W-1:0] addr,
                             input logic [tsp_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (addr)
            tsp_pkg::REG_DESK_WIDTH:    desk_w = data[tsp_pkg::POS_W-1:0];
            tsp_pkg::REG_DESK_HEIGHT:   desk_h = data[tsp_pkg::POS_W-1:0];
            tsp_pkg::REG_ALLOW_OVERRUN: overrun_en = data[0];
            default: ;
        endcase
    endtask

    // Hold the sender until every result is back, then let the pipe empty
    task automatic settle();
        while (pending_requests.size() != 0 || expected_heads.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Pick a coordinate near a centre, clamped inside 0..desk-1
    function automatic logic [tsp_pkg::POS_W-1:0] pick_near(input int centre, input int desk);
        int c;
        c = (centre > desk - 1) ? desk - 1 : centre;
        c = c + int'($urandom_range(16)) - 8;
        if (c < 0) c = 0;
        if (c > desk - 1) c = desk - 1;
        return c[tsp_pkg::POS_W-1:0];
    endfunction

    // Mostly a target followed by enough ticks to reach it, plus some noise
    task automatic queue_random_moves(input int n);
        int                        made;
        int                        dx;
        int                        dy;
        int                        ticks;
        logic [tsp_pkg::POS_W-1:0] gx;
        logic [tsp_pkg::POS_W-1:0] gy;
        made = 0;
        while (made < n) begin
            if ($urandom_range(99) < 10) begin
                queue_req(1'($urandom_range(1)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 1'($urandom_range(1)));
                made++;
            end else begin
                if ($urandom_range(7) == 0 || desk_w == 0 || desk_h == 0) begin
                    gx = 8'($urandom_range(255));
                    gy = 8'($urandom_range(255));
                end else begin
                    gx = pick_near(plan_x, int'(desk_w));
                    gy = pick_near(plan_y, int'(desk_h));
                end
                queue_req(tsp_pkg::REQ_TARGET, gx, gy, 1'($urandom_range(1)));
                dx = int'(gx) - plan_x;
                dy = int'(gy) - plan_y;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                ticks = dx + dy + int'($urandom_range(2));
                if ($urandom_range(5) == 0) ticks = int'($urandom_range(ticks));
                if (ticks > 48) ticks = 48;
                for (int k = 0; k < ticks; k++)
                    queue_req(tsp_pkg::REQ_TICK, 8'($urandom_range(255)),
                              8'($urandom_range(255)), 1'($urandom_range(1)));
                if (gx < desk_w && gy < desk_h && ticks >= dx + dy) begin
                    plan_x = int'(gx);
                    plan_y = int'(gy);
                end
                made += ticks + 1;
            end
        end
    endtask

    // Offer the oldest pending request; keep it steady until it is taken
    always @(negedge i_clk) begin : request_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_valid         <= 1'b1;
                i_req_type      <= pending_requests[0].kind;
                i_target_x      <= pending_requests[0].tx;
                i_target_y      <= pending_requests[0].ty;
                i_laser_request <= pending_requests[0].laser;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Capture each accepted request and predict its result
    always @(posedge i_clk) begin : request_capture
        t_head_req r;
        req_taken = i_rst_n && i_valid && !o_stall;
        if (req_taken) begin
            r.kind  = i_req_type;
            r.tx    = i_target_x;
            r.ty    = i_target_y;
            r.laser = i_laser_request;
            expected_heads.push_back(advance_head(r));
            void'(pending_requests.pop_front());
        end
    end

    // Receiver stall: random, or a long hold when asked for
    always @(negedge i_clk) begin : result_receiver
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_head_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_heads.size() == 0) begin
                report_mismatch("result with nothing outstanding", 0, 1);
            end else begin
                want = expected_heads.pop_front();
                if (o_coil_pattern !== want.coils)
                    report_mismatch("coil_pattern", 32'(want.coils), 32'(o_coil_pattern));
                if (o_head_x !== want.x)
                    report_mismatch("head_x", 32'(want.x), 32'(o_head_x));
                if (o_head_y !== want.y)
                    report_mismatch("head_y", 32'(want.y), 32'(o_head_y));
                if (o_busy_res !== want.busy)
                    report_mismatch("busy_res", 32'(want.busy), 32'(o_busy_res));
                if (o_target_rejected !== want.rejected)
                    report_mismatch("target_rejected", 32'(want.rejected),
                                    32'(o_target_rejected));
                if (o_step_blocked !== want.blocked)
                    report_mismatch("step_blocked", 32'(want.blocked), 32'(o_step_blocked));
                if (o_laser_out !== want.laser)
                    report_mismatch("laser_out", 32'(want.laser), 32'(o_laser_out));
            end
        end
    end

    // Drop the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset desk: idle tick, reached target, rejections, then a short move
        queue_req(tsp_pkg::REQ_TICK, 8'd0, 8'd0, 1'b1);
        queue_req(tsp_pkg::REQ_TARGET, 8'd0, 8'd0, 1'b0);
        queue_req(tsp_pkg::REQ_TARGET, 8'd128, 8'd10, 1'b1);
        queue_req(tsp_pkg::REQ_TARGET, 8'd10, 8'd64, 1'b1);
        queue_req(tsp_pkg::REQ_TARGET, 8'd255, 8'd255, 1'b1);
        queue_req(tsp_pkg::REQ_TARGET, 8'd127, 8'd63, 1'b1);
        queue_req(tsp_pkg::REQ_TARGET, 8'd5, 8'd1, 1'b1);
        for (int k = 0; k < 6; k++)
            queue_req(tsp_pkg::REQ_TICK, 8'd0, 8'd0, k[0]);
        settle();

        // Shrink the desk under the head: laser gated, return step blocked
        write_reg(tsp_pkg::REG_DESK_WIDTH, 32'd3);
        @(posedge i_clk);
        queue_req(tsp_pkg::REQ_TICK, 8'd0, 8'd0, 1'b1);
        queue_req(tsp_pkg::REQ_TARGET, 8'd1, 8'd0, 1'b1);
        queue_req(tsp_pkg::REQ_TICK, 8'd0, 8'd0, 1'b1);
        settle();

        // Overrun lets the head walk back in, phase ring wrapping downwards
        write_reg(tsp_pkg::REG_ALLOW_OVERRUN, 32'd1);
        @(posedge i_clk);
        for (int k = 0; k < 6; k++)
            queue_req(tsp_pkg::REQ_TICK, 8'd255, 8'd255, 1'b1);
        settle();

        // Zero-sized desk: every target rejected
        write_reg(tsp_pkg::REG_DESK_WIDTH, 32'd0);
        write_reg(tsp_pkg::REG_DESK_HEIGHT, 32'd0);
        write_reg(tsp_pkg::REG_ALLOW_OVERRUN, 32'd0);
        @(posedge i_clk);
        queue_req(tsp_pkg::REQ_TARGET, 8'd0, 8'd0, 1'b1);
        queue_req(tsp_pkg::REQ_TICK, 8'd0, 8'd0, 1'b1);
        settle();
        plan_x = int'(head_x);
        plan_y = int'(head_y);

        // Full desk, sender light and receiver heavy idling
        write_reg(tsp_pkg::REG_DESK_WIDTH, 32'd255);
        write_reg(tsp_pkg::REG_DESK_HEIGHT, 32'd255);
        @(posedge i_clk);
        queue_random_moves(180);
        settle();

        // Small random desk with overrun, idling swapped
        tx_idle_pct = 72;
        rx_idle_pct = 35;
        write_reg(tsp_pkg::REG_DESK_WIDTH, $urandom_range(16, 60));
        write_reg(tsp_pkg::REG_DESK_HEIGHT, $urandom_range(16, 60));
        write_reg(tsp_pkg::REG_ALLOW_OVERRUN, 32'd1);
        @(posedge i_clk);
        queue_random_moves(150);
        settle();

        // Larger desk, no idling, receiver holds off to back up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(tsp_pkg::REG_DESK_WIDTH, $urandom_range(60, 254));
        write_reg(tsp_pkg::REG_DESK_HEIGHT, $urandom_range(60, 254));
        write_reg(tsp_pkg::REG_ALLOW_OVERRUN, 32'd0);
        @(posedge i_clk);
        queue_random_moves(150);
        hold_request = 200;
        settle();

        // Tiny desk without overrun: head often stranded outside
        write_reg(tsp_pkg::REG_DESK_WIDTH, $urandom_range(1, 20));
        write_reg(tsp_pkg::REG_DESK_HEIGHT, $urandom_range(1, 20));
        @(posedge i_clk);
        queue_random_moves(100);
        settle();

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
design/tsp_pkg.sv
design/two_axis_stepper_positioner.sv
tb/sv/tb_two_axis_stepper_positioner.sv
